>>> hdl/string_instruction_step_unit_macros.svh
// Assertion macros used by the string instruction step unit checker.
`ifndef STRING_INSTRUCTION_STEP_UNIT_MACROS_SVH
`define STRING_INSTRUCTION_STEP_UNIT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define SISU_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define SISU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sisu_pkg.sv
// Types and constants of the string instruction step unit.
`timescale 1ns / 1ps

package sisu_pkg;

    // String operation codes.
    typedef enum logic [1:0] {
        ACT_MOVE  = 2'd0,
        ACT_CMP   = 2'd1,
        ACT_SCAN  = 2'd2,
        ACT_STORE = 2'd3
    } action_t;

    // Repeat prefix codes.
    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_REP   = 2'd1,
        PFX_REPZ  = 2'd2,
        PFX_REPNZ = 2'd3
    } prefix_t;

    // Operand size codes; the unused code behaves as dword.
    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_WORD  = 2'd1;
    localparam logic [1:0] SZ_DWORD = 2'd2;

    // Bit positions inside the flags field.
    localparam int FL_CF = 0;
    localparam int FL_PF = 1;
    localparam int FL_AF = 2;
    localparam int FL_ZF = 3;
    localparam int FL_SF = 4;
    localparam int FL_OF = 5;

    localparam int FLAGS_W = 6;

    // One input word.
    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         size_code;
        logic [1:0]         prefix;
        logic [31:0]        src_ptr;
        logic [31:0]        dst_ptr;
        logic [31:0]        count;
        logic               dir_flag;
        logic [31:0]        accum;
        logic [31:0]        src_data;
        logic [31:0]        dst_data;
        logic [FLAGS_W-1:0] flags_in;
    } item_t;

    // One result word.
    typedef struct packed {
        logic               executed;
        logic [31:0]        new_src_ptr;
        logic [31:0]        new_dst_ptr;
        logic [31:0]        new_count;
        logic [FLAGS_W-1:0] flags_out;
        logic               store_valid;
        logic [31:0]        store_addr;
        logic [31:0]        store_data;
        logic               repeat_res;
    } result_t;

endpackage

>>> hdl/sisu_step.sv
// Combinational datapath of one string instruction iteration.
`timescale 1ns / 1ps

module sisu_step (
    input  sisu_pkg::item_t   item,
    output sisu_pkg::result_t res
);
    import sisu_pkg::*;

    logic [2:0]         bytes;
    logic [31:0]        mask;
    logic [31:0]        step_val;
    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [31:0]        diff;
    logic               msb_r;
    logic               msb_ov;
    logic [31:0]        ov_vec;
    logic [FLAGS_W-1:0] sub_flags;
    logic [FLAGS_W-1:0] flags_new;
    logic               prefixed;
    logic               do_exec;
    logic [31:0]        count_dec;

    // Operand size decode: byte count and data mask.
    always_comb begin
        case (item.size_code)
            SZ_BYTE: begin
                bytes = 3'd1;
                mask  = 32'h0000_00FF;
            end
            SZ_WORD: begin
                bytes = 3'd2;
                mask  = 32'h0000_FFFF;
            end
            default: begin
                bytes = 3'd4;
                mask  = 32'hFFFF_FFFF;
            end
        endcase
    end

    assign step_val = item.dir_flag ? (32'd0 - {29'd0, bytes}) : {29'd0, bytes};

    // Subtraction operands: compare uses the source, scan the accumulator.
    assign op_a   = ((item.action == ACT_CMP) ? item.src_data : item.accum) & mask;
    assign op_b   = item.dst_data & mask;
    assign diff   = (op_a - op_b) & mask;
    assign ov_vec = (op_a ^ op_b) & (op_a ^ diff);

    // Sign and overflow come from the top bit of the operand size.
    always_comb begin
        case (item.size_code)
            SZ_BYTE: begin
                msb_r  = diff[7];
                msb_ov = ov_vec[7];
            end
            SZ_WORD: begin
                msb_r  = diff[15];
                msb_ov = ov_vec[15];
            end
            default: begin
                msb_r  = diff[31];
                msb_ov = ov_vec[31];
            end
        endcase
    end

    // Arithmetic flags of the subtraction.
    always_comb begin
        sub_flags        = '0;
        sub_flags[FL_CF] = (op_a < op_b);
        sub_flags[FL_PF] = ~(^diff[7:0]);
        sub_flags[FL_AF] = op_a[4] ^ op_b[4] ^ diff[4];
        sub_flags[FL_ZF] = (diff == 32'd0);
        sub_flags[FL_SF] = msb_r;
        sub_flags[FL_OF] = msb_ov;
    end

    assign prefixed  = (item.prefix != PFX_NONE);
    assign do_exec   = !prefixed || (item.count != 32'd0);
    assign count_dec = item.count - 32'd1;
    assign flags_new = (item.action == ACT_CMP || item.action == ACT_SCAN)
                       ? sub_flags : item.flags_in;

    // Result assembly, including the repeat decision.
    always_comb begin
        res             = '0;
        res.new_src_ptr = item.src_ptr;
        res.new_dst_ptr = item.dst_ptr;
        res.new_count   = item.count;
        res.flags_out   = item.flags_in;
        res.store_addr  = item.dst_ptr;
        if (do_exec) begin
            res.executed    = 1'b1;
            res.new_dst_ptr = item.dst_ptr + step_val;
            res.flags_out   = flags_new;
            if (item.action == ACT_MOVE || item.action == ACT_CMP) begin
                res.new_src_ptr = item.src_ptr + step_val;
            end
            if (item.action == ACT_MOVE) begin
                res.store_valid = 1'b1;
                res.store_data  = item.src_data & mask;
            end else if (item.action == ACT_STORE) begin
                res.store_valid = 1'b1;
                res.store_data  = item.accum & mask;
            end
            if (prefixed) begin
                res.new_count = count_dec;
                if (count_dec != 32'd0) begin
                    if (item.action == ACT_MOVE || item.action == ACT_STORE) begin
                        res.repeat_res = 1'b1;
                    end else if (item.prefix == PFX_REPNZ) begin
                        res.repeat_res = ~flags_new[FL_ZF];
                    end else begin
                        res.repeat_res = flags_new[FL_ZF];
                    end
                end
            end
        end
    end

endmodule

>>> hdl/string_instruction_step_unit.sv
// Top level of the string instruction step unit.
// Usage:
// The s_ channel carries one word per string iteration: the operation, size,
// prefix, pointers, count, direction flag, accumulator, both memory operands
// and the incoming flags. The m_ channel returns one result word per input
// word: executed flag, stepped pointers, new count, flags, store request and
// the repeat decision. Both channels use valid and ready handshakes.
// Each word is captured in an input register, processed by the step logic
// and held in an output register, so a result passes two register stages
// between the s_ handshake and the m_ side.
// Throughput is one word per cycle while m_ready holds; the step logic is
// one subtract with its flags and two pointer adds between the two registers.
// When the receiver stalls, the output register holds its word and the input
// register fills; s_ready then drops until m_ready returns.
// A synchronous low aresetn empties both stages; no result is shown after it.
`timescale 1ns / 1ps

module string_instruction_step_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [1:0]  s_size_code,
    input  logic [1:0]  s_prefix,
    input  logic [31:0] s_src_ptr,
    input  logic [31:0] s_dst_ptr,
    input  logic [31:0] s_count,
    input  logic        s_dir_flag,
    input  logic [31:0] s_accum,
    input  logic [31:0] s_src_data,
    input  logic [31:0] s_dst_data,
    input  logic [5:0]  s_flags_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_executed,
    output logic [31:0] m_new_src_ptr,
    output logic [31:0] m_new_dst_ptr,
    output logic [31:0] m_new_count,
    output logic [5:0]  m_flags_out,
    output logic        m_store_valid,
    output logic [31:0] m_store_addr,
    output logic [31:0] m_store_data,
    output logic        m_repeat_res
);
    import sisu_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    logic    out_valid_reg;
    result_t res_next;
    logic    out_load;
    logic    in_load;

    // Ready chain: the output stage frees when empty or taken.
    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            item_reg.action    <= s_action;
            item_reg.size_code <= s_size_code;
            item_reg.prefix    <= s_prefix;
            item_reg.src_ptr   <= s_src_ptr;
            item_reg.dst_ptr   <= s_dst_ptr;
            item_reg.count     <= s_count;
            item_reg.dir_flag  <= s_dir_flag;
            item_reg.accum     <= s_accum;
            item_reg.src_data  <= s_src_data;
            item_reg.dst_data  <= s_dst_data;
            item_reg.flags_in  <= s_flags_in;
        end
    end

    // Step logic between the two registers.
    sisu_step u_step (
        .item (item_reg),
        .res  (res_next)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    // Result ports.
    assign m_valid       = out_valid_reg;
    assign m_executed    = res_reg.executed;
    assign m_new_src_ptr = res_reg.new_src_ptr;
    assign m_new_dst_ptr = res_reg.new_dst_ptr;
    assign m_new_count   = res_reg.new_count;
    assign m_flags_out   = res_reg.flags_out;
    assign m_store_valid = res_reg.store_valid;
    assign m_store_addr  = res_reg.store_addr;
    assign m_store_data  = res_reg.store_data;
    assign m_repeat_res  = res_reg.repeat_res;

endmodule

>>> hdl/sisu_checker.sv
// Port-level checker for the string instruction step unit, with its bind.
`timescale 1ns / 1ps
`include "string_instruction_step_unit_macros.svh"

module sisu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_executed,
    input logic [31:0] m_new_count,
    input logic        m_store_valid,
    input logic [31:0] m_store_data,
    input logic        m_repeat_res
);

    // A stalled result word stays offered.
    `SISU_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // A skipped iteration neither stores nor repeats.
    `SISU_ASSERT_SAME(a_skip_quiet, aclk, aresetn, m_valid && !m_executed, !m_store_valid && !m_repeat_res, "skipped iteration requested work")

    // Store data is zero when no store is requested.
    `SISU_ASSERT_SAME(a_store_data_zero, aclk, aresetn, m_valid && !m_store_valid, m_store_data == 32'd0, "store data without store")

    // A repeat is only asked for while count remains.
    `SISU_ASSERT_SAME(a_repeat_count, aclk, aresetn, m_valid && m_repeat_res, m_new_count != 32'd0, "repeat with exhausted count")

endmodule

bind string_instruction_step_unit sisu_checker u_sisu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_executed    (m_executed),
    .m_new_count   (m_new_count),
    .m_store_valid (m_store_valid),
    .m_store_data  (m_store_data),
    .m_repeat_res  (m_repeat_res)
);
